// ===== hdl/risk_penalized_ucb_score_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the risk penalised UCB score block
// Clocked on clk, switched off while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef RISK_PENALIZED_UCB_SCORE_ASSERT_SVH
`define RISK_PENALIZED_UCB_SCORE_ASSERT_SVH

// same-cycle implication
`define RPUS_ASSERT_IMP(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
    else $error("rpus check failed");

// next-cycle implication
`define RPUS_ASSERT_NXT(lbl, ant, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
    else $error("rpus check failed");

`endif

// ===== hdl/rpus_pkg.sv =====
// ----------------------------------------------------------------------------
// rpus_pkg
// Widths, cell layout and shared types of the risk penalised UCB score block.
// ----------------------------------------------------------------------------
`default_nettype none

package rpus_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int VISIT_BITS = 24;
  localparam int TV_W       = 32;
  localparam int CONF_W     = 17;
  localparam int GAIN_W     = 24;
  localparam int EPS_W      = 16;
  localparam int CFG_IDX_W  = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_EXPLORE_GAIN  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_RISK_GAIN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VISIT_EPSILON = 2'd2;

  localparam logic [GAIN_W-1:0] EXPLORE_GAIN_RST = 24'd92682;
  localparam logic [GAIN_W-1:0] RISK_GAIN_RST    = 24'd65536;
  localparam logic [EPS_W-1:0]  VISIT_EPS_RST    = 16'd1;

  // arithmetic widths
  localparam int DEN_W     = VISIT_BITS + FRAC_BITS;
  localparam int REM_W     = DEN_W + 1;
  localparam int NUM_W     = TV_W + FRAC_BITS;
  localparam int Q_W       = NUM_W;
  localparam int X_W       = VISIT_BITS + 1;
  localparam int EXP2_W    = 5;
  localparam int Y_W       = 32;
  localparam int LOG2_W    = EXP2_W + FRAC_BITS;
  localparam int RATIO_Q_W = LOG2_W + FRAC_BITS;
  localparam int RATIO_W   = 62 - FRAC_BITS;
  localparam int SQ_IN_W   = RATIO_W + FRAC_BITS;
  localparam int ROOT_W    = SQ_IN_W / 2;
  localparam int SQ_REM_W  = ROOT_W + 3;
  localparam int EXPL_W    = GAIN_W + ROOT_W - FRAC_BITS;
  localparam int PEN_W     = CONF_W + GAIN_W - FRAC_BITS;
  localparam int SUM_W     = EXPL_W + 2;

  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [TV_W-1:0] SCORE_MIN = 32'h8000_0000;
  localparam logic [TV_W-1:0] SCORE_MAX = 32'h7FFF_FFFF;

  // cell layout along the chain
  localparam int MEAN_STEPS  = TV_W;
  localparam int LOG_STEPS   = FRAC_BITS;
  localparam int RATIO_STEPS = RATIO_Q_W;
  localparam int C_LN        = LOG_STEPS;
  localparam int C_RINIT     = C_LN + 1;
  localparam int C_RDIV0     = C_RINIT + 1;
  localparam int C_SINIT     = C_RDIV0 + RATIO_STEPS;
  localparam int C_SQRT0     = C_SINIT + 1;
  localparam int C_EXPL      = C_SQRT0 + ROOT_W;
  localparam int C_SUM       = C_EXPL + 1;
  localparam int N_CELLS     = C_SUM + 1;

  typedef struct packed {
    logic [REM_W-1:0] rem;
    logic [NUM_W-1:0] num;
    logic [Q_W-1:0]   quo;
  } div_t;

  typedef struct packed {
    logic [SQ_REM_W-1:0] rem;
    logic [SQ_IN_W-1:0]  num;
    logic [ROOT_W-1:0]   root;
  } sqrt_t;

  typedef struct packed {
    logic mdiv;
    logic logs;
    logic ln;
    logic rinit;
    logic rdiv;
    logic sinit;
    logic sqrt;
    logic expl;
    logic sum;
  } cell_ops_t;

  typedef struct packed {
    logic                 node_valid;
    logic                 tv_neg;
    logic                 visits_nz;
    logic                 den_zero;
    logic                 ln_nz;
    logic [DEN_W-1:0]     den;
    div_t                 mdiv;
    logic [EXP2_W-1:0]    exp2;
    logic [Y_W-1:0]       y;
    logic [FRAC_BITS-1:0] frac;
    logic [LOG2_W-1:0]    ln;
    div_t                 rdiv;
    sqrt_t                sq;
    logic                 pen_neg;
    logic [PEN_W-1:0]     pen_mag;
    logic [EXPL_W-1:0]    explore;
    logic [TV_W-1:0]      score;
    logic                 saturated;
  } stage_t;

  typedef struct packed {
    logic [TV_W-1:0] score;
    logic            saturated;
  } result_t;

  // which operations the cell at a given place performs
  function automatic cell_ops_t ops_of(input int k);
    cell_ops_t o;
    o.mdiv  = (k < MEAN_STEPS);
    o.logs  = (k < LOG_STEPS);
    o.ln    = (k == C_LN);
    o.rinit = (k == C_RINIT);
    o.rdiv  = (k >= C_RDIV0) && (k < C_SINIT);
    o.sinit = (k == C_SINIT);
    o.sqrt  = (k >= C_SQRT0) && (k < C_EXPL);
    o.expl  = (k == C_EXPL);
    o.sum   = (k == C_SUM);
    return o;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/rpus_in_if.sv =====
// ----------------------------------------------------------------------------
// rpus_in_if
// Node channel: valid/ready and one child node per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpus_in_if;
  logic                   valid;
  logic                   ready;
  logic                   node_valid;
  logic signed [31:0]     total_value;
  logic        [23:0]     visit_count;
  logic        [16:0]     confidence;
  logic        [23:0]     parent_visit_count;

  modport source (output valid, node_valid, total_value, visit_count, confidence,
                  parent_visit_count, input ready);
  modport sink (input valid, node_valid, total_value, visit_count, confidence,
                parent_visit_count, output ready);
endinterface

`default_nettype wire

// ===== hdl/rpus_out_if.sv =====
// ----------------------------------------------------------------------------
// rpus_out_if
// Score channel: valid/ready and one score per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface rpus_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] score;
  logic               saturated;

  modport source (output valid, score, saturated, input ready);
  modport sink (input valid, score, saturated, output ready);
endinterface

`default_nettype wire

// ===== hdl/rpus_cell.sv =====
// ----------------------------------------------------------------------------
// rpus_cell
// One cell of the score chain: division, squaring, log multiply, set-up, root, exploration and final sum steps.
// ----------------------------------------------------------------------------
`default_nettype none

module rpus_cell import rpus_pkg::*; (
  input  logic              clk,
  input  logic              en,
  input  cell_ops_t         ops,
  input  logic [GAIN_W-1:0] explore_gain,
  input  stage_t            stage_i,
  output stage_t            stage_o
);

  stage_t stage_nxt;

  // restoring division: one quotient bit
  function automatic div_t div_step(input div_t s, input logic [DEN_W-1:0] dv);
    logic [REM_W:0] t;
    logic           qb;
    div_t           r;
    t  = {s.rem, s.num[NUM_W-1]};
    qb = (t >= {2'b00, dv});
    if (qb) begin
      t = t - {2'b00, dv};
    end
    r.rem = t[REM_W-1:0];
    r.num = {s.num[NUM_W-2:0], 1'b0};
    r.quo = {s.quo[Q_W-2:0], qb};
    return r;
  endfunction

  // digit-by-digit square root: one root bit
  function automatic sqrt_t sqrt_step(input sqrt_t s);
    logic [SQ_REM_W+1:0] t;
    logic [SQ_REM_W+1:0] trial;
    sqrt_t               r;
    t     = {s.rem, s.num[SQ_IN_W-1 -: 2]};
    trial = {{(SQ_REM_W-ROOT_W){1'b0}}, s.root, 2'b01};
    if (t >= trial) begin
      t      = t - trial;
      r.root = {s.root[ROOT_W-2:0], 1'b1};
    end else begin
      r.root = {s.root[ROOT_W-2:0], 1'b0};
    end
    r.rem = t[SQ_REM_W-1:0];
    r.num = {s.num[SQ_IN_W-3:0], 2'b00};
    return r;
  endfunction

  logic [2*Y_W-1:0]         sq_prod;
  logic [Y_W:0]             sq_top;
  logic [LOG2_W+31:0]       ln_prod;
  logic [GAIN_W+ROOT_W-1:0] ex_prod;
  logic [RATIO_W-1:0]       ratio;
  logic signed [TV_W+1:0]   mean;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  pen;

  always_comb begin
    stage_nxt = stage_i;

    // mean division step
    if (ops.mdiv) begin
      stage_nxt.mdiv = div_step(stage_i.mdiv, stage_i.den);
    end

    // log2 fraction bit by squaring
    sq_prod = stage_i.y * stage_i.y;
    sq_top  = sq_prod[2*Y_W-1:Y_W-1];
    if (ops.logs) begin
      stage_nxt.frac = {stage_i.frac[FRAC_BITS-2:0], sq_top[Y_W]};
      stage_nxt.y    = sq_top[Y_W] ? sq_top[Y_W:1] : sq_top[Y_W-1:0];
    end

    // natural log from log2
    ln_prod = {stage_i.exp2, stage_i.frac} * LN2_Q32;
    if (ops.ln) begin
      stage_nxt.ln    = ln_prod[LOG2_W+31:32];
      stage_nxt.ln_nz = |ln_prod[LOG2_W+31:32];
    end

    // ratio division set-up
    if (ops.rinit) begin
      stage_nxt.rdiv.rem = '0;
      stage_nxt.rdiv.num = {stage_i.ln, {(NUM_W-LOG2_W){1'b0}}};
      stage_nxt.rdiv.quo = '0;
      stage_nxt.den_zero = (stage_i.den == '0);
    end

    if (ops.rdiv) begin
      stage_nxt.rdiv = div_step(stage_i.rdiv, stage_i.den);
    end

    // ratio clamp, root set-up
    if (stage_i.den_zero) begin
      ratio = stage_i.ln_nz ? {RATIO_W{1'b1}} : '0;
    end else begin
      ratio = {{(RATIO_W-RATIO_Q_W){1'b0}}, stage_i.rdiv.quo[RATIO_Q_W-1:0]};
    end
    if (ops.sinit) begin
      stage_nxt.sq.rem  = '0;
      stage_nxt.sq.num  = {ratio, {FRAC_BITS{1'b0}}};
      stage_nxt.sq.root = '0;
    end

    if (ops.sqrt) begin
      stage_nxt.sq = sqrt_step(stage_i.sq);
    end

    // exploration term
    ex_prod = explore_gain * stage_i.sq.root;
    if (ops.expl) begin
      stage_nxt.explore = ex_prod[GAIN_W+ROOT_W-1:FRAC_BITS];
    end

    // final sum and clipping
    if (!stage_i.visits_nz) begin
      mean = '0;
    end else if (stage_i.tv_neg) begin
      mean = -$signed({2'b00, stage_i.mdiv.quo[TV_W-1:0]});
    end else begin
      mean = $signed({2'b00, stage_i.mdiv.quo[TV_W-1:0]});
    end
    pen = $signed({{(SUM_W-PEN_W){1'b0}}, stage_i.pen_mag});
    sum = SUM_W'(mean) + $signed({2'b00, stage_i.explore});
    sum = stage_i.pen_neg ? sum + pen : sum - pen;
    if (ops.sum) begin
      priority if (!stage_i.node_valid) begin
        stage_nxt.score     = SCORE_MIN;
        stage_nxt.saturated = 1'b0;
      end else if (sum > $signed({{(SUM_W-TV_W){1'b0}}, SCORE_MAX})) begin
        stage_nxt.score     = SCORE_MAX;
        stage_nxt.saturated = 1'b1;
      end else if (sum < $signed({{(SUM_W-TV_W){1'b1}}, SCORE_MIN})) begin
        stage_nxt.score     = SCORE_MIN;
        stage_nxt.saturated = 1'b1;
      end else begin
        stage_nxt.score     = sum[TV_W-1:0];
        stage_nxt.saturated = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      stage_o <= stage_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/risk_penalized_ucb_score.sv =====
// ----------------------------------------------------------------------------
// risk_penalized_ucb_score
// UCB selection score with a risk penalty, one child node per beat.
// ----------------------------------------------------------------------------
// Takes one node per clock and returns its score through a chain of
// 89 cells (32 mean division cells beside 16 log2 squaring cells, a log
// multiply, a ratio set-up cell, 37 ratio division cells, a root set-up cell,
// 31 square root cells, the exploration multiply and the final sum), then a
// two-beat output buffer. The chain only stalls when that buffer is full and
// the score side is not taking a beat.
// Configuration writes are taken at any time but are meant for idle periods.
`default_nettype none

module risk_penalized_ucb_score import rpus_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  rpus_in_if.sink              in_ch,
  rpus_out_if.source           out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [GAIN_W-1:0]    cfg_wdata
);

  // configuration registers
  logic [GAIN_W-1:0] explore_gain_r;
  logic [GAIN_W-1:0] risk_gain_r;
  logic [EPS_W-1:0]  visit_eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      explore_gain_r <= EXPLORE_GAIN_RST;
      risk_gain_r    <= RISK_GAIN_RST;
      visit_eps_r    <= VISIT_EPS_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_EXPLORE_GAIN:  explore_gain_r <= cfg_wdata;
        REG_RISK_GAIN:     risk_gain_r    <= cfg_wdata;
        REG_VISIT_EPSILON: visit_eps_r    <= cfg_wdata[EPS_W-1:0];
        default:           ;
      endcase
    end
  end

  // chain advance: output buffer has room or is being drained
  logic       en;
  logic [1:0] cnt_r;

  assign en          = (cnt_r != 2'd2) || out_ch.ready;
  assign in_ch.ready = en;

  // front end: operand preparation
  stage_t                   prep;
  logic [TV_W-1:0]          tv_mag;
  logic [X_W-1:0]           x;
  logic [EXP2_W-1:0]        e;
  logic [X_W+Y_W-2:0]       x_sh;
  logic                     pen_neg;
  logic [CONF_W-1:0]        pm;
  logic [CONF_W+GAIN_W-1:0] pen_prod;

  always_comb begin
    prep = '0;
    prep.node_valid = in_ch.node_valid;
    prep.tv_neg     = in_ch.total_value[TV_W-1];
    tv_mag = prep.tv_neg ? (~in_ch.total_value + 1'b1) : in_ch.total_value;
    prep.visits_nz  = |in_ch.visit_count;
    prep.den        = {in_ch.visit_count, visit_eps_r};
    prep.mdiv.rem   = {{(REM_W-FRAC_BITS){1'b0}}, tv_mag[TV_W-1:FRAC_BITS]};
    prep.mdiv.num   = {tv_mag[FRAC_BITS-1:0], {(NUM_W-FRAC_BITS){1'b0}}};
    prep.mdiv.quo   = '0;

    // log2 operand normalised to Q1.31
    x = {1'b0, in_ch.parent_visit_count} + 1'b1;
    e = '0;
    for (int i = 0; i < X_W; i++) begin
      if (x[i]) begin
        e = EXP2_W'(i);
      end
    end
    x_sh      = {x, {(Y_W-1){1'b0}}} >> e;
    prep.exp2 = e;
    prep.y    = x_sh[Y_W-1:0];
    prep.frac = '0;

    // risk penalty
    pen_neg  = in_ch.confidence > CONF_W'(1 << FRAC_BITS);
    pm       = pen_neg ? in_ch.confidence - CONF_W'(1 << FRAC_BITS)
                       : CONF_W'(1 << FRAC_BITS) - in_ch.confidence;
    pen_prod = pm * risk_gain_r;
    prep.pen_neg = pen_neg;
    prep.pen_mag = pen_prod[CONF_W+GAIN_W-1:FRAC_BITS];
  end

  // cell chain
  stage_t             cell_in [N_CELLS];
  stage_t             cell_out[N_CELLS];
  logic [N_CELLS-1:0] vld_r;

  for (genvar k = 0; k < N_CELLS; k++) begin : g_cell
    if (k == 0) begin : g_head
      assign cell_in[k] = prep;
    end else begin : g_link
      assign cell_in[k] = cell_out[k-1];
    end
    rpus_cell u_cell (
      .clk          (clk),
      .en           (en),
      .ops          (ops_of(k)),
      .explore_gain (explore_gain_r),
      .stage_i      (cell_in[k]),
      .stage_o      (cell_out[k])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[N_CELLS-2:0], in_ch.valid};
    end
  end

  // two-beat output buffer
  result_t mem_r [2];
  logic    wr_ptr_r;
  logic    rd_ptr_r;
  logic    push;
  logic    pop;

  assign push = en && vld_r[N_CELLS-1];
  assign pop  = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= '{score: cell_out[N_CELLS-1].score,
                           saturated: cell_out[N_CELLS-1].saturated};
    end
  end

  assign out_ch.valid     = (cnt_r != 2'd0);
  assign out_ch.score     = mem_r[rd_ptr_r].score;
  assign out_ch.saturated = mem_r[rd_ptr_r].saturated;

endmodule

`default_nettype wire

// ===== hdl/rpus_checker.sv =====
// ----------------------------------------------------------------------------
// rpus_checker
// Port-level checks of the score block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "risk_penalized_ucb_score_assert.svh"

module rpus_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] score,
  input logic        saturated
);

  // a held beat stays offered
  `RPUS_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)
  // and keeps its score
  `RPUS_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(score))
  // clipping only ever lands on the range limits
  `RPUS_ASSERT_IMP(a_sat_limit, out_valid && saturated,
                   score == 32'h7FFF_FFFF || score == 32'h8000_0000)
  // a draining sink never blocks the node side
  `RPUS_ASSERT_IMP(a_no_block, out_ready, in_ready)

endmodule

bind risk_penalized_ucb_score rpus_checker u_rpus_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .score     (out_ch.score),
  .saturated (out_ch.saturated)
);

`default_nettype wire

// ===== verif/rpus_score_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rpus_score_checker
// Watches the node and score channels, predicts each score from the node
// beat and the current register values, and compares in order.
// ----------------------------------------------------------------------------
`default_nettype none

module rpus_score_checker import rpus_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  rpus_in_if                   in_ch,
  rpus_out_if                  out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [GAIN_W-1:0]    cfg_wdata,
  output int                   n_fail,
  output int                   n_pending,
  output int                   n_scores,
  output int                   n_sat
);

  logic [63:0] gain_explore;
  logic [63:0] gain_risk;
  logic [63:0] eps;
  result_t     score_q[$];

  // log2 in Q.16 by repeated squaring of the normalised argument
  function automatic logic [63:0] log2_q(input logic [63:0] x);
    int unsigned e;
    logic [63:0] y;
    logic [63:0] fr;
    e  = 0;
    fr = 0;
    while (e < 63 && (x >> (e + 1)) != 0) e++;
    y = (e <= 31) ? (x << (31 - e)) : (x >> (e - 31));
    for (int i = 0; i < FRAC_BITS; i++) begin
      y  = (y * y) >> 31;
      fr = fr << 1;
      if (y >= 64'h1_0000_0000) begin
        y  = y >> 1;
        fr = fr | 1;
      end
    end
    return (64'(e) << FRAC_BITS) | fr;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic result_t node_score(input logic nv, input logic [31:0] tv,
                                         input logic [23:0] vis,
                                         input logic [16:0] conf,
                                         input logic [23:0] par);
    result_t     r;
    logic [63:0] den, mag, lnq, ratio, root, expl, pm, rmax;
    logic signed [63:0] mean, pen, sum;
    logic        neg, pneg;
    rmax = (64'd1 << (62 - FRAC_BITS)) - 1;
    if (!nv) begin
      r.score     = SCORE_MIN;
      r.saturated = 1'b0;
      return r;
    end
    den  = (64'(vis) << FRAC_BITS) + eps;
    neg  = tv[31];
    mag  = neg ? 64'(-tv) : 64'(tv);
    if (neg && mag == 0) mag = 64'h8000_0000;
    mag  = mag & 64'hFFFF_FFFF;
    mean = 0;
    if (vis != 0) begin
      mean = $signed(64'((mag << FRAC_BITS) / den));
      if (neg) mean = -mean;
    end
    lnq = (log2_q(64'(par) + 1) * 64'(LN2_Q32)) >> 32;
    if (den == 0) ratio = (lnq == 0) ? 64'd0 : rmax;
    else          ratio = (lnq << FRAC_BITS) / den;
    if (ratio > rmax) ratio = rmax;
    root = int_sqrt(ratio << FRAC_BITS);
    expl = (gain_explore * root) >> FRAC_BITS;
    pneg = conf > 17'h10000;
    pm   = pneg ? 64'(conf) - 64'h10000 : 64'h10000 - 64'(conf);
    pm   = (pm * gain_risk) >> FRAC_BITS;
    pen  = pneg ? -$signed(pm) : $signed(pm);
    sum  = mean + $signed(expl) - pen;
    if (sum > 64'sd2147483647) begin
      r.score = SCORE_MAX; r.saturated = 1'b1;
    end else if (sum < -64'sd2147483648) begin
      r.score = SCORE_MIN; r.saturated = 1'b1;
    end else begin
      r.score = sum[31:0]; r.saturated = 1'b0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t MISMATCH %s: got %h want %h", $time, what, got, want);
    n_fail++;
  endtask

  assign n_pending = score_q.size();

  always_ff @(posedge clk) begin
    result_t want;
    if (!rst_n) begin
      gain_explore <= 64'(EXPLORE_GAIN_RST);
      gain_risk    <= 64'(RISK_GAIN_RST);
      eps          <= 64'(VISIT_EPS_RST);
      score_q.delete();
      n_fail   = 0;
      n_scores <= 0;
      n_sat    <= 0;
    end else begin
      // register mirror
      if (cfg_we) begin
        case (cfg_idx)
          REG_EXPLORE_GAIN:  gain_explore <= 64'(cfg_wdata);
          REG_RISK_GAIN:     gain_risk    <= 64'(cfg_wdata);
          REG_VISIT_EPSILON: eps          <= 64'(cfg_wdata[EPS_W-1:0]);
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready)
        score_q.push_back(node_score(in_ch.node_valid, in_ch.total_value,
                                     in_ch.visit_count, in_ch.confidence,
                                     in_ch.parent_visit_count));
      // score beat against oldest prediction
      if (out_ch.valid && out_ch.ready) begin
        n_scores <= n_scores + 1;
        if (out_ch.saturated) n_sat <= n_sat + 1;
        if (score_q.size() == 0) begin
          report_mismatch("unexpected beat", out_ch.score, 0);
        end else begin
          want = score_q.pop_front();
          if (out_ch.score !== want.score)
            report_mismatch("score", out_ch.score, want.score);
          if (out_ch.saturated !== want.saturated)
            report_mismatch("saturated", 32'(out_ch.saturated), 32'(want.saturated));
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== verif/tb_risk_penalized_ucb_score.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_risk_penalized_ucb_score
// Directed corner nodes then random nodes over several register settings,
// with random gaps and back-pressure; scores checked by rpus_score_checker.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_risk_penalized_ucb_score;
  import rpus_pkg::*;

  localparam int LATENCY   = 90;
  localparam int WD_LIMIT  = 20000;
  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [GAIN_W-1:0]    cfg_wdata;
  int                   n_fail, n_pending, n_scores, n_sat;
  int                   n_nodes;
  int                   idle_run;
  bit                   hold_long;
  bit                   stim_done;

  rpus_in_if  in_ch();
  rpus_out_if out_ch();

  risk_penalized_ucb_score u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata)
  );

  rpus_score_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_idx(cfg_idx), .cfg_wdata(cfg_wdata),
    .n_fail(n_fail), .n_pending(n_pending), .n_scores(n_scores), .n_sat(n_sat)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // score side: random stalls, one long hold-off to fill the chain
  initial begin
    int n;
    out_ch.ready = 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (hold_long) begin
        out_ch.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_long = 1'b0;
      end
      out_ch.ready <= 1'b1;
      n = $urandom_range(1, 30);
      repeat (n) @(posedge clk);
      n = gap_len();
      if (n > 0) begin
        out_ch.ready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_run <= 0;
    else
      idle_run <= idle_run + 1;
    if (idle_run >= WD_LIMIT) begin
      $display("Watchdog expired");
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic send_node(input logic nv, input logic [31:0] tv, input logic [23:0] vis,
                           input logic [16:0] conf, input logic [23:0] par);
    in_ch.valid              <= 1'b1;
    in_ch.node_valid         <= nv;
    in_ch.total_value        <= tv;
    in_ch.visit_count        <= vis;
    in_ch.confidence         <= conf;
    in_ch.parent_visit_count <= par;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    n_nodes++;
  endtask

  task automatic pause_sender();
    int n;
    n = gap_len();
    if (n > 0) begin
      in_ch.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [GAIN_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [23:0] rand_count();
    case ($urandom_range(0, 3))
      0: return 24'($urandom_range(0, 15));
      1: return 24'($urandom_range(0, 1000));
      2: return 24'($urandom);
      default: return $urandom_range(0, 1) ? 24'hFFFFFF : 24'd1;
    endcase
  endfunction

  function automatic logic [16:0] rand_conf();
    case ($urandom_range(0, 3))
      0: return 17'h10000;
      1: return 17'd0;
      2: return 17'($urandom_range(0, 65536));
      default: return 17'($urandom);
    endcase
  endfunction

  task automatic random_nodes(input int n);
    for (int i = 0; i < n; i++) begin
      send_node($urandom_range(0, 15) != 0, $urandom, rand_count(), rand_conf(),
                rand_count());
      if ($urandom_range(0, 2) == 0) pause_sender();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0; cfg_idx = '0; cfg_wdata = '0;
    in_ch.valid = 1'b0; in_ch.node_valid = 1'b0; in_ch.total_value = '0;
    in_ch.visit_count = '0; in_ch.confidence = '0; in_ch.parent_visit_count = '0;
    n_nodes = 0; hold_long = 1'b0; stim_done = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners at reset gains
    send_node(1'b0, 32'h1234_5678, 24'd5, 17'h10000, 24'd9);
    send_node(1'b1, 32'h0, 24'd0, 17'h10000, 24'd0);
    send_node(1'b1, 32'h7FFF_FFFF, 24'd1, 17'h10000, 24'd1);
    send_node(1'b1, 32'h8000_0000, 24'd1, 17'h10000, 24'd1);
    send_node(1'b1, 32'h8000_0000, 24'hFFFFFF, 17'd0, 24'hFFFFFF);
    send_node(1'b1, 32'h7FFF_FFFF, 24'hFFFFFF, 17'h1FFFF, 24'hFFFFFF);
    send_node(1'b1, 32'h0001_0000, 24'd0, 17'd0, 24'hFFFFFF);
    send_node(1'b1, 32'hFFFF_FFFF, 24'd3, 17'h18000, 24'd100);
    drain();

    // zero epsilon: zero denominator, ratio clamp; big gains saturate
    write_reg(REG_VISIT_EPSILON, 24'd0);
    write_reg(REG_EXPLORE_GAIN, 24'hFFFFFF);
    write_reg(REG_RISK_GAIN, 24'hFFFFFF);
    write_reg(REG_SPARE, 24'h123456);
    send_node(1'b1, 32'h0, 24'd0, 17'd0, 24'd0);
    send_node(1'b1, 32'h0, 24'd0, 17'h10000, 24'd1);
    send_node(1'b1, 32'h8000_0000, 24'd0, 17'd0, 24'hFFFFFF);
    send_node(1'b1, 32'h7FFF_FFFF, 24'd0, 17'h1FFFF, 24'hFFFFFF);
    random_nodes(150);
    drain();

    // zero gains, max epsilon
    write_reg(REG_VISIT_EPSILON, 24'hFFFF);
    write_reg(REG_EXPLORE_GAIN, 24'd0);
    write_reg(REG_RISK_GAIN, 24'd0);
    random_nodes(150);
    drain();

    // random gains, with one long score hold-off under a full input stream
    write_reg(REG_VISIT_EPSILON, 24'($urandom_range(1, 65535)));
    write_reg(REG_EXPLORE_GAIN, 24'($urandom));
    write_reg(REG_RISK_GAIN, 24'($urandom_range(0, 262144)));
    hold_long = 1'b1;
    for (int i = 0; i < 200; i++)
      send_node(1'b1, $urandom, rand_count(), rand_conf(), rand_count());
    random_nodes(100);
    drain();

    // back to reset values
    write_reg(REG_VISIT_EPSILON, 24'(VISIT_EPS_RST));
    write_reg(REG_EXPLORE_GAIN, EXPLORE_GAIN_RST);
    write_reg(REG_RISK_GAIN, RISK_GAIN_RST);
    random_nodes(200);
    drain();

    $display("Covered %0d nodes, %0d scores (%0d saturated) over five register settings",
             n_nodes, n_scores, n_sat);
    if (n_fail == 0) $display("Test completed successfully");
    else             $display("Test completed with failures");
    $finish;
  end

endmodule

`default_nettype wire

// ===== risk_penalized_ucb_score.f =====
+incdir+hdl
hdl/rpus_pkg.sv
hdl/rpus_in_if.sv
hdl/rpus_out_if.sv
hdl/rpus_cell.sv
hdl/risk_penalized_ucb_score.sv
hdl/rpus_checker.sv
verif/rpus_score_checker.sv
verif/tb_risk_penalized_ucb_score.sv
